/* src/pes_to_transport_stream_packetizer_assert.svh */
// Assertion macros used by the packetizer top level.
// Each macro places one labeled concurrent assertion clocked on the rising edge
// and disabled while the asynchronous reset is asserted.
`ifndef PES_TO_TRANSPORT_STREAM_PACKETIZER_ASSERT_SVH
`define PES_TO_TRANSPORT_STREAM_PACKETIZER_ASSERT_SVH

// Same-cycle implication.
`define PTSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("packetizer assertion failed");

// Next-cycle implication.
`define PTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("packetizer assertion failed");

`endif

/* src/ptsp_pkg.sv */
// ----------------------------------------------------------------------------
// PES packetizer package
// Sizes, header codes and the packet descriptor type shared by the packetizer modules.
// ----------------------------------------------------------------------------
package ptsp_pkg;

	localparam int unsigned PayloadBytes = 184;
	localparam int unsigned PacketBytes  = 188;
	localparam int unsigned RamDepth     = 2 * PayloadBytes;
	localparam int unsigned RamAw        = $clog2(RamDepth);
	localparam int unsigned PidW         = 13;

	localparam logic [7:0] LAST_FILL     = 8'(PayloadBytes - 1);
	localparam logic [7:0] LAST_BYTE_POS = 8'(PacketBytes - 1);
	localparam logic [8:0] PACKET_LEN    = 9'(PacketBytes);
	localparam logic [RamAw-1:0] BANK1_BASE = RamAw'(PayloadBytes);

	localparam logic [7:0] SYNC_BYTE   = 8'h47;
	localparam logic [7:0] STUFF_BYTE  = 8'hFF;
	localparam logic [7:0] FLAGS_DISC  = 8'h80;
	localparam logic [7:0] FLAGS_NONE  = 8'h00;
	localparam logic [3:0] AFC_PAYLOAD = 4'h1;
	localparam logic [3:0] AFC_ADAPT   = 4'h3;

	// One closed packet waiting for the back end.
	typedef struct packed {
		logic            bank;
		logic [7:0]      n;
		logic            pusi;
		logic [3:0]      cc;
		logic            disc;
		logic [PidW-1:0] pid;
	} ptsp_desc_t;

	// Byte write into the payload buffer.
	typedef struct packed {
		logic             we;
		logic [RamAw-1:0] addr;
		logic [7:0]       data;
	} ptsp_wr_t;

	// Byte read from the payload buffer.
	typedef struct packed {
		logic             re;
		logic [RamAw-1:0] addr;
	} ptsp_rd_t;

endpackage

/* src/ptsp_pes_if.sv */
// ----------------------------------------------------------------------------
// PES byte channel
// Valid/ready channel that carries one PES payload byte and its flags.
// ----------------------------------------------------------------------------
interface ptsp_pes_if;
	logic       valid;
	logic       ready;
	logic [7:0] pes_byte;
	logic       last_of_pes;
	logic       set_discontinuity;

	modport source (output valid, pes_byte, last_of_pes, set_discontinuity, input ready);
	modport sink   (input valid, pes_byte, last_of_pes, set_discontinuity, output ready);
endinterface

/* src/ptsp_ts_if.sv */
// ----------------------------------------------------------------------------
// Transport stream word channel
// Valid/ready channel that carries one 32-bit packet word.
// ----------------------------------------------------------------------------
interface ptsp_ts_if;
	logic        valid;
	logic        ready;
	logic [31:0] ts_word;
	logic        last_of_packet;

	modport source (output valid, ts_word, last_of_packet, input ready);
	modport sink   (input valid, ts_word, last_of_packet, output ready);
endinterface

/* src/ptsp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptsp_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// Write and registered read; the read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/ptsp_desc_fifo.sv */
// ----------------------------------------------------------------------------
// Packet descriptor queue
// Two-entry queue of closed packets between the front and the back end.
// ----------------------------------------------------------------------------
module ptsp_desc_fifo import ptsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ptsp_desc_t push_desc,
	input  logic       pop,
	output ptsp_desc_t head,
	output logic [1:0] count
);

	ptsp_desc_t mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	// Descriptor storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_desc;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head  = mem_q[rptr_q];
	assign count = count_q;

endmodule

/* src/ptsp_front.sv */
// ----------------------------------------------------------------------------
// Packetizer front end
// Accepts PES bytes into a buffer bank and closes packets into descriptors.
// ----------------------------------------------------------------------------
module ptsp_front import ptsp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	ptsp_pes_if.sink        pes_in,
	input  logic            cfg_we,
	input  logic [PidW-1:0] cfg_wdata,
	input  logic [1:0]      q_count,
	input  logic            back_busy,
	output ptsp_wr_t        wr,
	output logic            push,
	output ptsp_desc_t      push_desc
);

	logic [7:0]      fill_q;
	logic            bank_q;
	logic            first_q;
	logic [3:0]      cc_q;
	logic            pend_q;
	logic [PidW-1:0] pid_q;

	logic [1:0] banks_used;
	logic       accept;
	logic       close;
	logic       pend_now;
	logic       has_flags;

	// The bank being filled is free while fewer than two banks are owned downstream.
	assign banks_used    = q_count + {1'b0, back_busy};
	assign pes_in.ready  = (banks_used < 2'd2);
	assign accept        = pes_in.valid && pes_in.ready;
	assign close         = accept && ((fill_q == LAST_FILL) || pes_in.last_of_pes);
	assign pend_now      = pend_q || pes_in.set_discontinuity;
	// A flags byte exists when at least two stuffing bytes remain.
	assign has_flags     = (fill_q < (LAST_FILL - 8'd1));

	// Buffer write for every accepted byte.
	assign wr.we   = accept;
	assign wr.addr = bank_q ? (RamAw'(fill_q) + BANK1_BASE) : RamAw'(fill_q);
	assign wr.data = pes_in.pes_byte;

	// Descriptor of the packet that this byte closes.
	assign push           = close;
	assign push_desc.bank = bank_q;
	assign push_desc.n    = fill_q + 8'd1;
	assign push_desc.pusi = first_q;
	assign push_desc.cc   = cc_q;
	assign push_desc.disc = has_flags && pend_now;
	assign push_desc.pid  = pid_q;

	// Fill level, bank select, header counters and the PID register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= 8'd0;
			bank_q  <= 1'b0;
			first_q <= 1'b1;
			cc_q    <= 4'd0;
			pend_q  <= 1'b0;
			pid_q   <= '0;
		end else begin
			if (cfg_we) begin
				pid_q <= cfg_wdata;
			end
			if (accept) begin
				if (close) begin
					fill_q <= 8'd0;
					bank_q <= ~bank_q;
					cc_q   <= cc_q + 4'd1;
				end else begin
					fill_q <= fill_q + 8'd1;
				end
				if (pes_in.last_of_pes) begin
					first_q <= 1'b1;
				end else if (close) begin
					first_q <= 1'b0;
				end
				pend_q <= (close && has_flags) ? 1'b0 : pend_now;
			end
		end
	end

endmodule

/* src/ptsp_back.sv */
// ----------------------------------------------------------------------------
// Packetizer back end
// Walks the 188 bytes of each packet, packs them into words and drives output.
// ----------------------------------------------------------------------------
module ptsp_back import ptsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] q_count,
	input  ptsp_desc_t head,
	output logic       pop,
	output logic       busy,
	output ptsp_rd_t   rd,
	input  logic [7:0] rdata,
	ptsp_ts_if.source  ts_out
);

	logic        active_q;
	logic [7:0]  k_q;
	ptsp_desc_t  d_q;

	logic        valid_s1;
	logic        ram_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [31:0] asm_q;
	logic [2:0]  asm_cnt_q;
	logic        asm_last_q;

	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic        out_last_q;

	logic        move;
	logic        consume;
	logic        issue;
	logic        adapt;
	logic [8:0]  pos_sum;
	logic        is_payload;
	logic [7:0]  pay_idx;
	logic [7:0]  const_byte;
	logic [7:0]  byte_in;

	// Handshake between the byte stage, the word assembler and the output register.
	assign move    = (asm_cnt_q == 3'd4) && (!out_valid_q || ts_out.ready);
	assign consume = valid_s1 && ((asm_cnt_q != 3'd4) || move);
	assign issue   = active_q && (!valid_s1 || consume);
	assign pop     = !active_q && (q_count != 2'd0);
	assign busy    = active_q;

	// Payload occupies the packet tail from position 188 - n on.
	assign adapt      = (d_q.n != 8'(PayloadBytes));
	assign pos_sum    = {1'b0, k_q} + {1'b0, d_q.n};
	assign is_payload = (pos_sum >= PACKET_LEN);
	assign pay_idx    = 8'(pos_sum - PACKET_LEN);

	assign rd.re   = issue && is_payload;
	assign rd.addr = d_q.bank ? (RamAw'(pay_idx) + BANK1_BASE) : RamAw'(pay_idx);

	// Header, adaptation field and stuffing bytes.
	always_comb begin
		const_byte = STUFF_BYTE;
		if (k_q == 8'd0) begin
			const_byte = SYNC_BYTE;
		end else if (k_q == 8'd1) begin
			const_byte = {1'b0, d_q.pusi, 1'b0, d_q.pid[12:8]};
		end else if (k_q == 8'd2) begin
			const_byte = d_q.pid[7:0];
		end else if (k_q == 8'd3) begin
			const_byte = {(adapt ? AFC_ADAPT : AFC_PAYLOAD), d_q.cc};
		end else if ((k_q == 8'd4) && adapt) begin
			const_byte = LAST_FILL - d_q.n;
		end else if ((k_q == 8'd5) && adapt && (d_q.n < LAST_FILL)) begin
			const_byte = d_q.disc ? FLAGS_DISC : FLAGS_NONE;
		end
	end

	assign byte_in = ram_s1 ? rdata : byte_s1;

	// Packet walk, byte stage, word assembly and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			k_q         <= 8'd0;
			valid_s1    <= 1'b0;
			asm_cnt_q   <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				k_q      <= 8'd0;
			end else if (issue) begin
				if (k_q == LAST_BYTE_POS) begin
					active_q <= 1'b0;
				end
				k_q <= k_q + 8'd1;
			end

			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end

			if (move || consume) begin
				asm_cnt_q <= (move ? 3'd0 : asm_cnt_q) + (consume ? 3'd1 : 3'd0);
			end

			if (move) begin
				out_valid_q <= 1'b1;
			end else if (ts_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the pipeline.
	always_ff @(posedge clk) begin
		if (pop) begin
			d_q <= head;
		end
		if (issue) begin
			ram_s1  <= is_payload;
			byte_s1 <= const_byte;
			last_s1 <= (k_q == LAST_BYTE_POS);
		end
		if (consume) begin
			asm_q      <= {asm_q[23:0], byte_in};
			asm_last_q <= last_s1;
		end
		if (move) begin
			out_word_q <= asm_q;
			out_last_q <= asm_last_q;
		end
	end

	assign ts_out.valid          = out_valid_q;
	assign ts_out.ts_word        = out_word_q;
	assign ts_out.last_of_packet = out_last_q;

endmodule

/* src/pes_to_transport_stream_packetizer.sv */
// ----------------------------------------------------------------------------
// PES to transport stream packetizer
// Packs PES payload bytes into 188-byte transport packets of 47 words.
// ----------------------------------------------------------------------------
// Usage:
//   pes_in carries one PES byte per transaction with last_of_pes and
//   set_discontinuity. ts_out carries one 32-bit word per transaction, first
//   packet byte in bits 31 to 24, last_of_packet on the 47th word.
//   cfg_we with cfg_wdata loads the 13-bit PID; write it only while idle.
// Data flow:
//   Bytes are accepted one per cycle, while a bank is free, into a two-bank
//   buffer. A packet closes on its 184th byte or on a byte with last_of_pes.
//   The back end walks the 188 packet bytes at one byte per cycle while ts_out
//   does not stall, reading payload bytes through the buffer read port and
//   generating header, adaptation and stuffing bytes, then takes the next
//   descriptor. Words pass through the byte stage, word assembler and output register.
//   pes_in.ready drops while both banks hold packets not yet sent.
// Reset and stall:
//   Reset clears the fill level, continuity counter, pending discontinuity and
//   PID and marks the next packet as the start of a PES. The buffer needs no
//   clearing. When ts_out stalls, the output register holds its word and the
//   back end stops; the front keeps filling while a bank is free.
`include "pes_to_transport_stream_packetizer_assert.svh"

module pes_to_transport_stream_packetizer import ptsp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	ptsp_pes_if.sink        pes_in,
	ptsp_ts_if.source       ts_out,
	input  logic            cfg_we,
	input  logic [PidW-1:0] cfg_wdata
);

	ptsp_wr_t   wr;
	ptsp_rd_t   rd;
	logic [7:0] rdata;
	logic       push;
	ptsp_desc_t push_desc;
	logic       pop;
	ptsp_desc_t head;
	logic [1:0] q_count;
	logic       back_busy;

	// Byte intake and packet close.
	ptsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pes_in    (pes_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_count   (q_count),
		.back_busy (back_busy),
		.wr        (wr),
		.push      (push),
		.push_desc (push_desc)
	);

	// Two-bank payload buffer.
	ptsp_ram #(
		.Width (8),
		.Depth (RamDepth)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (rdata)
	);

	// Closed packets waiting for the back end.
	ptsp_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.count     (q_count)
	);

	// Packet generation and output.
	ptsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_count (q_count),
		.head    (head),
		.pop     (pop),
		.busy    (back_busy),
		.rd      (rd),
		.rdata   (rdata),
		.ts_out  (ts_out)
	);

	// A packet is only closed while the queue has room for it.
	`PTSP_ASSERT_NOW(a_push_not_full, clk, arst_n, push, q_count != 2'd2)
	// The back end only takes a descriptor that is present.
	`PTSP_ASSERT_NOW(a_pop_not_empty, clk, arst_n, pop, q_count != 2'd0)
	// At most two banks are ever owned by the queue and the back end together.
	`PTSP_ASSERT_NEXT(a_banks_bounded, clk, arst_n, push, (q_count + {1'b0, back_busy}) <= 2'd2)

endmodule

/* tb/sv/pes_to_transport_stream_packetizer_tb.sv */
// ----------------------------------------------------------------------------
// PES to transport stream packetizer testbench
// Feeds PES bytes through the valid/ready input channel in random bursts while
// the output channel stalls on its own pattern. A scoreboard predicts every
// 188-byte packet word by word and compares each received word with the
// oldest prediction. It runs directed corner cases first, then random PES
// blocks under a second PID setting, with one long output hold-off.
// ----------------------------------------------------------------------------

// One predicted packet word.
typedef struct packed {
	logic [31:0] word;
	logic        last;
} ts_beat_t;

// Predicts packets from accepted bytes and checks the received words.
class ts_scoreboard;
	logic [7:0]                  held_bytes [ptsp_pkg::PayloadBytes];
	int unsigned                 fill;
	bit                          start_of_pes;
	logic [3:0]                  cont_count;
	bit                          disc_pending;
	logic [ptsp_pkg::PidW-1:0]   pid;
	ts_beat_t                    expected_words [$];
	int                          errors;

	function new();
		fill         = 0;
		start_of_pes = 1'b1;
		cont_count   = '0;
		disc_pending = 1'b0;
		pid          = '0;
		errors       = 0;
	endfunction

	function void set_pid(logic [ptsp_pkg::PidW-1:0] value);
		pid = value;
	endfunction

	function int unsigned outstanding();
		return expected_words.size();
	endfunction

	// Account for one accepted input byte and queue a packet when one closes.
	function void note_byte(logic [7:0] data, logic last, logic disc);
		logic [7:0]  pkt [ptsp_pkg::PacketBytes];
		int unsigned stuffing;
		bit          adapt;
		ts_beat_t    beat;

		// The request is latched before the byte itself is handled.
		if (disc)
			disc_pending = 1'b1;
		if (fill < ptsp_pkg::PayloadBytes) begin
			held_bytes[fill] = data;
			fill++;
		end

		if (fill >= ptsp_pkg::PayloadBytes || last) begin
			stuffing = ptsp_pkg::PayloadBytes - fill;
			adapt    = fill < ptsp_pkg::PayloadBytes;
			for (int i = 0; i < ptsp_pkg::PacketBytes; i++)
				pkt[i] = ptsp_pkg::STUFF_BYTE;

			// Header: sync, start flag, PID and continuity counter.
			pkt[0] = ptsp_pkg::SYNC_BYTE;
			pkt[1] = {1'b0, start_of_pes, 1'b0, pid[12:8]};
			pkt[2] = pid[7:0];
			pkt[3] = {adapt ? ptsp_pkg::AFC_ADAPT : ptsp_pkg::AFC_PAYLOAD, cont_count};

			// A single stuffing byte leaves no room for the flags byte, so a
			// pending discontinuity waits for a later packet.
			if (adapt) begin
				pkt[4] = 8'(stuffing - 1);
				if (stuffing > 1) begin
					pkt[5] = disc_pending ? ptsp_pkg::FLAGS_DISC : ptsp_pkg::FLAGS_NONE;
					disc_pending = 1'b0;
				end
			end

			// The payload fills the tail of the packet.
			for (int i = 0; i < fill; i++)
				pkt[ptsp_pkg::PacketBytes - fill + i] = held_bytes[i];

			for (int w = 0; w < ptsp_pkg::PacketBytes / 4; w++) begin
				beat.word = {pkt[4*w], pkt[4*w+1], pkt[4*w+2], pkt[4*w+3]};
				beat.last = (w == ptsp_pkg::PacketBytes / 4 - 1);
				expected_words.push_back(beat);
			end
			cont_count++;
			start_of_pes = 1'b0;
			fill = 0;
		end

		if (last)
			start_of_pes = 1'b1;
	endfunction

	// Compare one received word with the oldest prediction.
	function void check_word(logic [31:0] word, logic last);
		ts_beat_t beat;

		if (expected_words.size() == 0) begin
			$error("unexpected ts_word %08h with no packet pending", word);
			errors++;
			return;
		end
		beat = expected_words.pop_front();
		if (beat.word !== word) begin
			$error("ts_word: expected %08h, actual %08h", beat.word, word);
			errors++;
		end
		if (beat.last !== last) begin
			$error("last_of_packet: expected %0b, actual %0b", beat.last, last);
			errors++;
		end
	endfunction
endclass

module pes_to_transport_stream_packetizer_tb;
	import ptsp_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 11;
	localparam int IDLE_CYCLES  = 20;
	localparam int HOLD_CYCLES  = 2000;
	// The hold-off starts once the two single-byte packets are out, while the
	// long directed PES is still being offered.
	localparam int HOLD_AFTER   = 94;
	localparam int MODE_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 200000;
	localparam int PHASE_BYTES  = 120;
	localparam int NO_DISC      = -1;

	// Output-side stall patterns.
	typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [PidW-1:0] cfg_wdata;

	ptsp_pes_if pes_in ();
	ptsp_ts_if  ts_out ();

	ts_scoreboard sb = new();

	int       burst_left = 0;
	int       words_seen = 0;
	int       hold_left  = 0;
	bit       held_once  = 1'b0;
	int       rx_cycle   = 0;
	rx_mode_t rx_mode    = RX_STEADY;

	pes_to_transport_stream_packetizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pes_in    (pes_in.sink),
		.ts_out    (ts_out.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Output monitor and receiver stall pattern in one process.
	always @(posedge clk) begin
		if (!arst_n) begin
			ts_out.ready <= 1'b0;
		end else begin
			if (ts_out.valid && ts_out.ready) begin
				sb.check_word(ts_out.ts_word, ts_out.last_of_packet);
				words_seen++;
			end
			// One long hold-off lets both buffer banks fill and stall the input.
			if (hold_left > 0) begin
				hold_left--;
				ts_out.ready <= 1'b0;
			end else if (!held_once && words_seen >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
				ts_out.ready <= 1'b0;
			end else begin
				rx_cycle++;
				if (rx_cycle % MODE_CYCLES == 0)
					rx_mode = rx_mode_t'($urandom_range(0, 2));
				case (rx_mode)
					RX_STEADY: ts_out.ready <= 1'b1;
					RX_RANDOM: ts_out.ready <= 1'($urandom_range(0, 1));
					default:   ts_out.ready <= (rx_cycle % 4 == 0);
				endcase
			end
		end
	end

	// Offer one byte, idling between bursts, and wait for the transaction.
	task automatic push_byte(input logic [7:0] data, input logic last, input logic disc);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				pes_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 48);
		end
		burst_left--;
		pes_in.valid             <= 1'b1;
		pes_in.pes_byte          <= data;
		pes_in.last_of_pes       <= last;
		pes_in.set_discontinuity <= disc;
		do @(posedge clk); while (!pes_in.ready);
		sb.note_byte(data, last, disc);
	endtask

	// Send one PES block of random bytes; disc_rate 0 means no random requests.
	task automatic send_pes(input int len, input int disc_pos, input int disc_rate);
		logic disc;

		for (int i = 0; i < len; i++) begin
			disc = (i == disc_pos) || (disc_rate > 0 && $urandom_range(1, disc_rate) == 1);
			push_byte(8'($urandom), i == len - 1, disc);
		end
	endtask

	// Send random PES blocks until about the given number of bytes went in.
	task automatic send_random_phase(input int target);
		int sent;
		int len;
		int pick;

		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				len = $urandom_range(1, 24);
			else if (pick < 92)
				len = $urandom_range(178, 184);
			else
				len = $urandom_range(185, 370);
			send_pes(len, NO_DISC, 12);
			sent += len;
		end
	endtask

	// Stop offering and wait until every predicted word has arrived.
	task automatic wait_idle(input int limit);
		int waited;

		pes_in.valid <= 1'b0;
		waited = 0;
		while (sb.outstanding() > 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pid(input logic [PidW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_pid(value);
	endtask

	// Main stimulus sequence.
	initial begin
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_wdata                = '0;
		pes_in.valid             = 1'b0;
		pes_in.pes_byte          = '0;
		pes_in.last_of_pes       = 1'b0;
		pes_in.set_discontinuity = 1'b0;
		ts_out.ready             = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed corner cases under the widest PID.
		write_pid({PidW{1'b1}});
		push_byte(8'h00, 1'b1, 1'b0);
		// A request on the closing byte already shows in that packet.
		push_byte(8'hFF, 1'b1, 1'b1);
		// A full packet without a PES end, then a packet with one stuffing byte:
		// the request made on the first byte stays pending through both.
		send_pes(2 * PayloadBytes - 1, 0, 0);
		// The next adaptation field with a flags byte carries the pending request.
		push_byte(8'h5A, 1'b1, 1'b0);
		wait_idle(DRAIN_LIMIT);

		// Random PES blocks under a second PID setting.
		write_pid(PidW'($urandom));
		send_random_phase(PHASE_BYTES);
		wait_idle(DRAIN_LIMIT);

		if (sb.outstanding() > 0) begin
			$error("%0d predicted words never arrived", sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#(CLK_PERIOD * 1000000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
